[design/bmsao_pkg.sv]
// Package: widths, codes and state type for the band min/max stretch block.
`timescale 1ns / 1ps
`default_nettype none
package bmsao_pkg;
   localparam int BANDS      = 64;
   localparam int COUNT_BITS = 32;
   localparam int BAND_AW    = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int SUM_W      = 40;
   localparam int NUM_W      = SUM_W + 15;
   localparam int DEN_W      = COUNT_BITS + 8;
   localparam int DCNT_W     = $clog2(NUM_W);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_W      = 16;
   localparam logic [15:0] ONE_Q15 = 16'd32768;

   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_ACCUM   = 2'd1;
   localparam logic [1:0] CMD_FINISH  = 2'd2;
   localparam logic [1:0] CMD_ENHANCE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_GAIN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BRIGHT_THR  = 1'd1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_ENH_MUL, ST_ENH_DIV, ST_ENH_OUT,
      ST_MEAN_DIV, ST_OFS_MUL, ST_OFS_DIV
   } state_type;
endpackage
`default_nettype wire

[design/bmsao_req_if.sv]
// Input channel interface: command, band and sample words.
`timescale 1ns / 1ps
`default_nettype none
interface bmsao_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [5:0] band;
   logic [7:0] sample;
   modport source (output valid, command, band, sample, input ready);
   modport sink   (input valid, command, band, sample, output ready);
endinterface
`default_nettype wire

[design/bmsao_rsp_if.sv]
// Result channel interface: enhanced value and band words.
`timescale 1ns / 1ps
`default_nettype none
interface bmsao_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] enhanced;
   logic [5:0]  out_band;
   modport source (output valid, enhanced, out_band, input ready);
   modport sink   (input valid, enhanced, out_band, output ready);
endinterface
`default_nettype wire

[design/bmsao_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module bmsao_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

[design/band_minmax_stretch_adaptive_offset.sv]
// Top level: per-band min/max contrast stretch with adaptive brightness offset.
//
//  channel  | dir | handshake         | word
//  req_ch   | in  | valid/ready       | command, band, sample
//  rsp_ch   | out | valid/ready       | enhanced, out_band
//  csr_*    | in  | write enable only | index, 16-bit data
//
// One item at a time. Clear acts at once. Accumulate reads the RAM, then writes back.
// Enhance reads, then runs the shared bit-serial divider when the band has a range
// and the scaled value is positive, then hands off the output. Finish, with a nonzero
// count and threshold, divides for the mean, then for the offset if below threshold.
// Reset clears the band valid bits at once, so no clearing pass is needed.
// A waiting result does not block input; only the next enhance waits for it.
`timescale 1ns / 1ps
`default_nettype none
module band_minmax_stretch_adaptive_offset
   import bmsao_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   bmsao_req_if.sink                 req_ch,
   bmsao_rsp_if.source               rsp_ch,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);
   state_type state_ff, state_in;

   logic [1:0]         cmd_ff;
   logic [5:0]         band_ff;
   logic [7:0]         sample_ff;
   logic [BANDS-1:0]   bvalid_ff, bvalid_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [15:0]        offset_ff, offset_in;
   logic [15:0]        gain_ff, thr_ff;
   logic [15:0]        mean_ff, mean_in;
   logic [8:0]         vlo_ff, vlo_in;     // sample - low, signed
   logic [7:0]         diff_ff, diff_in;   // high - low
   logic [15:0]        res_ff, res_in;
   logic               rv_ff, rv_in;
   logic [15:0]        enh_ff, enh_in;
   logic [5:0]         oband_ff, oband_in;

   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [DEN_W-1:0]   rem_ff, rem_in, den_ff, den_in;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;
   logic [DEN_W:0]     trial;
   logic [NUM_W-1:0]   quo_step;
   logic [DEN_W-1:0]   rem_step;
   logic               div_last;

   logic               ram_we;
   logic [15:0]        ram_wdata, ram_rdata;
   logic               req_fire, band_ok;
   logic [7:0]         lo, hi, nlo, nhi;
   logic [SUM_W:0]     sum_add;
   logic signed [26:0] enh_num;
   logic [31:0]        ofs_prod;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign band_ok      = int'(band_ff) < BANDS;

   bmsao_ram #(.WIDTH(16), .DEPTH(BANDS)) u_band_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (BAND_AW'(band_ff)),
      .wr_data (ram_wdata),
      .rd_en   (req_fire),
      .rd_addr (BAND_AW'(req_ch.band)),
      .rd_data (ram_rdata)
   );

   // an entry never written since clear reads as low 255, high 0
   assign lo  = bvalid_ff[BAND_AW'(band_ff)] ? ram_rdata[15:8] : 8'd255;
   assign hi  = bvalid_ff[BAND_AW'(band_ff)] ? ram_rdata[7:0]  : 8'd0;
   assign nlo = (sample_ff < lo) ? sample_ff : lo;
   assign nhi = (sample_ff > hi) ? sample_ff : hi;
   assign ram_wdata = {nlo, nhi};
   assign ram_we    = (state_ff == ST_READ) && (cmd_ff == CMD_ACCUM) && band_ok;

   assign sum_add = {1'b0, sum_ff} + {{(SUM_W-7){1'b0}}, sample_ff};

   // restoring divider step, one quotient bit per cycle
   assign trial    = {rem_ff, quo_ff[NUM_W-1]};
   assign rem_step = (trial >= {1'b0, den_ff}) ? DEN_W'(trial - {1'b0, den_ff})
                                               : trial[DEN_W-1:0];
   assign quo_step = {quo_ff[NUM_W-2:0], (trial >= {1'b0, den_ff})};
   assign div_last = (dcnt_ff == DCNT_W'(NUM_W - 1));

   assign enh_num  = 27'(signed'({{18{vlo_ff[8]}}, vlo_ff}) <<< 15)
                   + signed'({3'b0, 24'(offset_ff * diff_ff)});
   assign ofs_prod = gain_ff * (thr_ff - mean_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.command)
                  CMD_ACCUM, CMD_ENHANCE: state_in = ST_READ;
                  CMD_FINISH: begin
                     if (count_ff != '0 && thr_ff != '0) state_in = ST_MEAN_DIV;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            if (cmd_ff == CMD_ENHANCE) begin
               state_in = (band_ok && hi > lo) ? ST_ENH_MUL : ST_ENH_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ENH_MUL:  state_in = (enh_num > 0) ? ST_ENH_DIV : ST_ENH_OUT;
         ST_ENH_DIV:  if (div_last) state_in = ST_ENH_OUT;
         ST_ENH_OUT:  if (!rv_ff || rsp_ch.ready) state_in = ST_IDLE;
         ST_MEAN_DIV: begin
            if (div_last) begin
               state_in = (quo_step >= NUM_W'(thr_ff)) ? ST_IDLE : ST_OFS_MUL;
            end
         end
         ST_OFS_MUL:  state_in = ST_OFS_DIV;
         ST_OFS_DIV:  if (div_last) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      bvalid_in = bvalid_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      offset_in = offset_ff;
      mean_in   = mean_ff;
      vlo_in    = vlo_ff;
      diff_in   = diff_ff;
      res_in    = res_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      dcnt_in   = dcnt_ff;
      rv_in     = rv_ff && !rsp_ch.ready;
      enh_in    = enh_ff;
      oband_in  = oband_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.command == CMD_CLEAR) begin
                  bvalid_in = '0;
                  sum_in    = '0;
                  count_in  = '0;
               end else if (req_ch.command == CMD_FINISH) begin
                  offset_in = '0;
                  quo_in    = NUM_W'({sum_ff, 15'd0});
                  rem_in    = '0;
                  den_in    = DEN_W'({count_ff, 8'd0} - {8'd0, count_ff});
                  dcnt_in   = '0;
               end
            end
         end
         ST_READ: begin
            if (ram_we) begin
               bvalid_in[BAND_AW'(band_ff)] = 1'b1;
               sum_in   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
               count_in = (&count_ff) ? count_ff : count_ff + 1'b1;
            end
            vlo_in  = {1'b0, sample_ff} - {1'b0, lo};
            diff_in = hi - lo;
            res_in  = (offset_ff > ONE_Q15) ? ONE_Q15 : offset_ff;
         end
         ST_ENH_MUL: begin
            res_in  = '0;
            quo_in  = NUM_W'(unsigned'(enh_num));
            rem_in  = '0;
            den_in  = DEN_W'(diff_ff);
            dcnt_in = '0;
         end
         ST_ENH_DIV, ST_MEAN_DIV, ST_OFS_DIV: begin
            quo_in  = quo_step;
            rem_in  = rem_step;
            dcnt_in = dcnt_ff + 1'b1;
            if (div_last) begin
               if (state_ff == ST_ENH_DIV) begin
                  res_in = (quo_step > NUM_W'(ONE_Q15)) ? ONE_Q15 : quo_step[15:0];
               end else if (state_ff == ST_MEAN_DIV) begin
                  mean_in = quo_step[15:0];
               end else begin
                  offset_in = quo_step[15:0];
               end
            end
         end
         ST_OFS_MUL: begin
            quo_in  = NUM_W'(ofs_prod);
            rem_in  = '0;
            den_in  = DEN_W'(thr_ff);
            dcnt_in = '0;
         end
         ST_ENH_OUT: begin
            if (!rv_ff || rsp_ch.ready) begin
               rv_in    = 1'b1;
               enh_in   = res_ff;
               oband_in = band_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         bvalid_ff <= '0;
         sum_ff    <= '0;
         count_ff  <= '0;
         offset_ff <= '0;
         gain_ff   <= 16'd3277;
         thr_ff    <= 16'd16384;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         bvalid_ff <= bvalid_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         offset_ff <= offset_in;
         rv_ff     <= rv_in;
         if (csr_we) begin
            case (csr_index)
               REG_OFFSET_GAIN: gain_ff <= csr_wdata;
               REG_BRIGHT_THR:  thr_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff    <= req_ch.command;
         band_ff   <= req_ch.band;
         sample_ff <= req_ch.sample;
      end
      mean_ff  <= mean_in;
      vlo_ff   <= vlo_in;
      diff_ff  <= diff_in;
      res_ff   <= res_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      dcnt_ff  <= dcnt_in;
      enh_ff   <= enh_in;
      oband_ff <= oband_in;
   end

   assign rsp_ch.valid    = rv_ff;
   assign rsp_ch.enhanced = enh_ff;
   assign rsp_ch.out_band = oband_ff;
endmodule
`default_nettype wire
